// File: rtl/rrcd_pkg.sv
// rrcd_pkg: shared types, widths and codes of the round-robin category dispatcher
// used by rrcd_ctrl and round_robin_category_dispatcher; depends on nothing
`default_nettype none

package rrcd_pkg;

  localparam int unsigned MAX_SOURCES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_SOURCES);
  localparam int unsigned CNT_W       = $clog2(MAX_SOURCES + 1);
  localparam int unsigned SRC_W       = 4;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CAT_W       = 2;
  localparam int unsigned TAG_W       = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SRC_W-1:0] src_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [CAT_W-1:0] cat_t;
  typedef logic [TAG_W-1:0] tag_t;

  // category and destination codes
  localparam cat_t CAT_DONE  = 2'd3;
  localparam cat_t DEST_NONE = 2'd3;

  localparam cfg_t PRODUCER_COUNT_RST = 5'd4;

  // one result beat
  typedef struct packed {
    cat_t destination;
    tag_t routed_tag;
    src_t source_id;
    src_t next_source;
    logic end_marker;
    logic run_finished;
    logic last;
  } res_t;

  // number of sources at run start, clamped to 1..MAX_SOURCES
  function automatic cnt_t start_count(input cfg_t pc);
    cnt_t n;
    if (pc == '0) begin
      n = cnt_t'(1);
    end else if (32'(pc) > MAX_SOURCES) begin
      n = cnt_t'(MAX_SOURCES);
    end else begin
      n = cnt_t'(pc);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rrcd_ram.sv
// rrcd_ram: generic synchronous RAM, one write port and two registered read ports
// standalone, no package dependency
`default_nettype none

module rrcd_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: rtl/rrcd_ctrl.sv
// rrcd_ctrl: sequencer that reads, shifts and writes back the source list
// depends on rrcd_pkg; drives the source list RAM (rrcd_ram) from the top level
`default_nettype none

module rrcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrcd_pkg::cfg_t       producer_count_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rrcd_pkg::cat_t       category_i,
  input  rrcd_pkg::tag_t       item_tag_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output rrcd_pkg::res_t       res_o,
  output logic                 we_o,
  output rrcd_pkg::idx_t       waddr_o,
  output rrcd_pkg::src_t       wdata_o,
  output rrcd_pkg::idx_t       raddr_a_o,
  output rrcd_pkg::idx_t       raddr_b_o,
  input  rrcd_pkg::src_t       rdata_a_i,
  input  rrcd_pkg::src_t       rdata_b_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RD, S_DEC, S_SHR, S_SHW, S_POST, S_NXT, S_EMIT
  } state_e;

  state_e state_q, state_d;

  rrcd_pkg::cnt_t count_q, count_d;
  rrcd_pkg::idx_t pos_q, pos_d;
  rrcd_pkg::idx_t ptr_q, ptr_d;
  logic           running_q, running_d;
  logic           fin_q, fin_d;
  logic [1:0]     k_q, k_d;
  rrcd_pkg::cat_t cat_q, cat_d;
  rrcd_pkg::tag_t tag_q, tag_d;
  rrcd_pkg::src_t src_q, src_d;
  rrcd_pkg::res_t res_q, res_d;

  rrcd_pkg::cnt_t pos_inc;
  rrcd_pkg::idx_t pos_wrap;
  rrcd_pkg::cnt_t count_dec;
  rrcd_pkg::idx_t pos_after;

  // next position, modulo the current and the decremented count
  assign pos_inc   = rrcd_pkg::cnt_t'(pos_q) + rrcd_pkg::cnt_t'(1);
  assign pos_wrap  = (pos_inc == count_q) ? '0 : pos_inc[rrcd_pkg::IDX_W-1:0];
  assign count_dec = count_q - rrcd_pkg::cnt_t'(1);
  // pos_inc reaches at most count_dec + 1, so the wrap is 0 or 1
  assign pos_after = (pos_inc < count_dec) ? pos_inc[rrcd_pkg::IDX_W-1:0] :
                     (pos_inc == count_q && count_dec != rrcd_pkg::cnt_t'(1)) ?
                     rrcd_pkg::idx_t'(1) : '0;

  // sequencer next state and memory control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    running_d   = running_q;
    fin_d       = fin_q;
    k_d         = k_q;
    cat_d       = cat_q;
    tag_d       = tag_q;
    src_d       = src_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    we_o        = 1'b0;
    waddr_o     = ptr_q;
    wdata_o     = rrcd_pkg::src_t'(ptr_q);
    raddr_a_o   = pos_q;
    raddr_b_o   = pos_wrap;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cat_d = category_i;
          tag_d = item_tag_i;
          fin_d = 1'b0;
          k_d   = '0;
          if (!running_q) begin
            count_d   = rrcd_pkg::start_count(producer_count_i);
            pos_d     = '0;
            ptr_d     = '0;
            running_d = 1'b1;
            state_d   = S_FILL;
          end else begin
            state_d = S_RD;
          end
        end
      end
      // load the list with 0..count-1, one entry a cycle
      S_FILL: begin
        we_o = 1'b1;
        if (rrcd_pkg::cnt_t'(ptr_q) + rrcd_pkg::cnt_t'(1) == count_q) begin
          state_d = S_RD;
        end else begin
          ptr_d = ptr_q + rrcd_pkg::idx_t'(1);
        end
      end
      S_RD: begin
        raddr_a_o = pos_q;
        raddr_b_o = pos_wrap;
        state_d   = S_DEC;
      end
      S_DEC: begin
        src_d = rdata_a_i;
        if (cat_q != rrcd_pkg::CAT_DONE) begin
          res_d.destination  = cat_q;
          res_d.routed_tag   = tag_q;
          res_d.source_id    = rdata_a_i;
          res_d.next_source  = rdata_b_i;
          res_d.end_marker   = 1'b0;
          res_d.run_finished = 1'b0;
          res_d.last         = 1'b1;
          pos_d              = pos_wrap;
          state_d            = S_EMIT;
        end else begin
          ptr_d = pos_q;
          if (pos_inc < count_q) begin
            state_d = S_SHR;
          end else begin
            state_d = S_POST;
          end
        end
      end
      // retirement shift: read entry ptr+1
      S_SHR: begin
        raddr_b_o = ptr_q + rrcd_pkg::idx_t'(1);
        state_d   = S_SHW;
      end
      // retirement shift: write it back at ptr
      S_SHW: begin
        we_o    = 1'b1;
        wdata_o = rdata_b_i;
        ptr_d   = ptr_q + rrcd_pkg::idx_t'(1);
        if (rrcd_pkg::cnt_t'(ptr_q) + rrcd_pkg::cnt_t'(2) < count_q) begin
          state_d = S_SHR;
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        count_d = count_dec;
        if (count_dec == '0) begin
          fin_d     = 1'b1;
          k_d       = '0;
          running_d = 1'b0;
          pos_d     = '0;
          state_d   = S_EMIT;
        end else begin
          pos_d     = pos_after;
          raddr_b_o = pos_after;
          state_d   = S_NXT;
        end
      end
      S_NXT: begin
        res_d.destination  = rrcd_pkg::DEST_NONE;
        res_d.routed_tag   = '0;
        res_d.source_id    = src_q;
        res_d.next_source  = rdata_b_i;
        res_d.end_marker   = 1'b0;
        res_d.run_finished = 1'b0;
        res_d.last         = 1'b1;
        state_d            = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (fin_q && k_q != 2'd3) begin
            k_d = k_q + 2'd1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result beat: stored result, or the retirement and end markers of a run end
  always_comb begin
    res_o = res_q;
    if (fin_q) begin
      res_o.routed_tag   = '0;
      res_o.source_id    = src_q;
      res_o.next_source  = '0;
      if (k_q == '0) begin
        res_o.destination  = rrcd_pkg::DEST_NONE;
        res_o.end_marker   = 1'b0;
        res_o.run_finished = 1'b0;
        res_o.last         = 1'b0;
      end else begin
        res_o.destination  = rrcd_pkg::cat_t'(k_q - 2'd1);
        res_o.end_marker   = 1'b1;
        res_o.run_finished = 1'b1;
        res_o.last         = (k_q == 2'd3);
      end
    end
  end

  // state and registered values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      ptr_q     <= '0;
      running_q <= 1'b0;
      fin_q     <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      ptr_q     <= ptr_d;
      running_q <= running_d;
      fin_q     <= fin_d;
      k_q       <= k_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    cat_q <= cat_d;
    tag_q <= tag_d;
    src_q <= src_d;
    res_q <= res_d;
  end

  // a running list is never empty nor larger than the RAM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (count_q != '0 &&
                   32'(count_q) <= rrcd_pkg::MAX_SOURCES))
    else $error("active count out of range while running");

  // the position always points inside the active list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (rrcd_pkg::cnt_t'(pos_q) < count_q))
    else $error("round-robin position beyond active count");

  // one item at a time: after an accept the input side closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // run-end flag travels only with end markers, which never carry no-destination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.run_finished == res_o.end_marker &&
                     (!res_o.end_marker || res_o.destination != rrcd_pkg::DEST_NONE)))
    else $error("inconsistent end marker beat");

  // the list shift only runs on a done item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHW) |-> (cat_q == rrcd_pkg::CAT_DONE && !fin_q))
    else $error("list shift outside a retirement");

endmodule

`default_nettype wire

// File: rtl/round_robin_category_dispatcher.sv
// round_robin_category_dispatcher: top level with config register and output stage
// depends on rrcd_pkg, rrcd_ram and rrcd_ctrl
`default_nettype none

// Routes one item at a time from the polled source by its category and tracks the
// active source list in a 16-entry RAM with registered reads. An ordinary item
// passes through accept, RAM read, decode and the hand to the output register on
// its way to its result beat; the first item of a run first loads the list, one RAM
// write a cycle. A done item shifts each list entry behind the retired one down, a
// read then a write-back through the single write port, and then fetches the next
// source; the last retirement hands out four beats, one a cycle while the sink is
// ready. The output register holds a finished beat so the next item is taken
// meanwhile.
// producer_count is sampled only when a run starts; cfg_ready_o is always high.

module round_robin_category_dispatcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  rrcd_pkg::cfg_t       cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rrcd_pkg::cat_t       category_i,
  input  rrcd_pkg::tag_t       item_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rrcd_pkg::cat_t       destination_o,
  output rrcd_pkg::tag_t       routed_tag_o,
  output rrcd_pkg::src_t       source_id_o,
  output rrcd_pkg::src_t       next_source_o,
  output logic                 end_marker_o,
  output logic                 run_finished_o,
  output logic                 last_o
);

  rrcd_pkg::cfg_t producer_count_q;
  logic           res_valid;
  logic           res_ready;
  rrcd_pkg::res_t res;
  logic           out_valid_q;
  rrcd_pkg::res_t out_res_q;

  logic           ram_we;
  rrcd_pkg::idx_t ram_waddr;
  rrcd_pkg::src_t ram_wdata;
  rrcd_pkg::idx_t ram_raddr_a;
  rrcd_pkg::idx_t ram_raddr_b;
  rrcd_pkg::src_t ram_rdata_a;
  rrcd_pkg::src_t ram_rdata_b;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      producer_count_q <= rrcd_pkg::PRODUCER_COUNT_RST;
    end else if (cfg_valid_i) begin
      producer_count_q <= cfg_data_i;
    end
  end

  // source list storage
  rrcd_ram #(
    .Depth (rrcd_pkg::MAX_SOURCES),
    .Width (rrcd_pkg::SRC_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // sequencer
  rrcd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .producer_count_i (producer_count_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .category_i       (category_i),
    .item_tag_i       (item_tag_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .we_o             (ram_we),
    .waddr_o          (ram_waddr),
    .wdata_o          (ram_wdata),
    .raddr_a_o        (ram_raddr_a),
    .raddr_b_o        (ram_raddr_b),
    .rdata_a_i        (ram_rdata_a),
    .rdata_b_i        (ram_rdata_b)
  );

  // output register, refilled in the cycle its beat leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign destination_o  = out_res_q.destination;
  assign routed_tag_o   = out_res_q.routed_tag;
  assign source_id_o    = out_res_q.source_id;
  assign next_source_o  = out_res_q.next_source;
  assign end_marker_o   = out_res_q.end_marker;
  assign run_finished_o = out_res_q.run_finished;
  assign last_o         = out_res_q.last;

endmodule

`default_nettype wire

// File: test/rrcd_route_checker.sv
// rrcd_route_checker: watches the config, item and result channels of the dispatcher,
// predicts every result beat and compares it field by field; depends on rrcd_pkg
`timescale 1ns / 1ps

module rrcd_route_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  rrcd_pkg::cfg_t cfg_data_i,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  rrcd_pkg::cat_t category_i,
  input  rrcd_pkg::tag_t item_tag_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  rrcd_pkg::cat_t destination_i,
  input  rrcd_pkg::tag_t routed_tag_i,
  input  rrcd_pkg::src_t source_id_i,
  input  rrcd_pkg::src_t next_source_i,
  input  logic           end_marker_i,
  input  logic           run_finished_i,
  input  logic           last_i,
  output logic [31:0]    mismatches_o,
  output logic [31:0]    pending_o
);

  // shadow of the dispatcher state
  rrcd_pkg::cfg_t count_reg;
  rrcd_pkg::src_t slot_src [rrcd_pkg::MAX_SOURCES];
  int unsigned    live_cnt;
  int unsigned    poll_pos;
  logic           in_run;

  // result beats still owed by the block, oldest first
  rrcd_pkg::res_t due_beats [$];
  int unsigned    errors;

  function automatic void push_beat(rrcd_pkg::cat_t dest, rrcd_pkg::tag_t tag,
                                    rrcd_pkg::src_t src, rrcd_pkg::src_t nxt,
                                    logic endm, logic fin, logic lst);
    rrcd_pkg::res_t r;
    r.destination  = dest;
    r.routed_tag   = tag;
    r.source_id    = src;
    r.next_source  = nxt;
    r.end_marker   = endm;
    r.run_finished = fin;
    r.last         = lst;
    due_beats.push_back(r);
  endfunction

  // work out the beats one accepted item causes
  function automatic void route_item(rrcd_pkg::cat_t cat, rrcd_pkg::tag_t tag);
    int unsigned    n;
    rrcd_pkg::src_t src;
    // a new run loads the list 0..n-1 from the clamped count
    if (!in_run || live_cnt == 0 || live_cnt > rrcd_pkg::MAX_SOURCES) begin
      n = count_reg;
      if (n < 1) begin
        n = 1;
      end else if (n > rrcd_pkg::MAX_SOURCES) begin
        n = rrcd_pkg::MAX_SOURCES;
      end
      for (int i = 0; i < n; i++) begin
        slot_src[i] = rrcd_pkg::src_t'(i);
      end
      live_cnt = n;
      poll_pos = 0;
      in_run   = 1'b1;
    end
    if (poll_pos >= live_cnt) begin
      poll_pos = 0;
    end
    src = slot_src[poll_pos];

    // ordinary item goes straight through
    if (cat != rrcd_pkg::CAT_DONE) begin
      poll_pos = (poll_pos + 1) % live_cnt;
      push_beat(cat, tag, src, slot_src[poll_pos], 1'b0, 1'b0, 1'b1);
      return;
    end

    // retire: close the gap, then step past the entry that moved in
    for (int i = poll_pos; i + 1 < live_cnt; i++) begin
      slot_src[i] = slot_src[i + 1];
    end
    live_cnt--;
    if (live_cnt != 0) begin
      poll_pos = (poll_pos + 1) % live_cnt;
      push_beat(rrcd_pkg::DEST_NONE, '0, src, slot_src[poll_pos], 1'b0, 1'b0, 1'b1);
      return;
    end

    // last source gone: retirement beat plus one end marker per destination
    push_beat(rrcd_pkg::DEST_NONE, '0, src, '0, 1'b0, 1'b0, 1'b0);
    for (int k = 0; k < 3; k++) begin
      push_beat(rrcd_pkg::cat_t'(k), '0, src, '0, 1'b1, 1'b1, logic'(k == 2));
    end
    poll_pos = 0;
    in_run   = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // track config, predict on item beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin : watch
    rrcd_pkg::res_t want;
    if (!rst_ni) begin
      count_reg = rrcd_pkg::PRODUCER_COUNT_RST;
      live_cnt  = 0;
      poll_pos  = 0;
      in_run    = 1'b0;
      errors    = 0;
      due_beats.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        count_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        route_item(category_i, item_tag_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (due_beats.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, got dest %0d tag 0x%0h",
                   $time, destination_i, routed_tag_i);
          errors++;
        end else begin
          want = due_beats.pop_front();
          check_field("destination", 32'(want.destination), 32'(destination_i));
          check_field("routed_tag", 32'(want.routed_tag), 32'(routed_tag_i));
          check_field("source_id", 32'(want.source_id), 32'(source_id_i));
          check_field("next_source", 32'(want.next_source), 32'(next_source_i));
          check_field("end_marker", 32'(want.end_marker), 32'(end_marker_i));
          check_field("run_finished", 32'(want.run_finished), 32'(run_finished_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
    end
    pending_o    <= 32'(due_beats.size());
    mismatches_o <= 32'(errors);
  end

endmodule

// File: test/testbench.sv
// testbench: drives items and config writes into the dispatcher, paces the result
// sink and reports the verdict; depends on rrcd_pkg, rrcd_route_checker and the RTL
`timescale 1ns / 1ps

module testbench;

  localparam rrcd_pkg::cat_t CAT_SPORTS  = 2'd0;
  localparam rrcd_pkg::cat_t CAT_WEATHER = 2'd1;
  localparam rrcd_pkg::cat_t CAT_NEWS    = 2'd2;

  // result sink pacing modes
  localparam int SINK_OPEN   = 0;
  localparam int SINK_COIN   = 1;
  localparam int SINK_TIGHT  = 2;
  localparam int SINK_TOGGLE = 3;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SETTLE_WAIT  = 8;
  localparam int DRAIN_WAIT   = 24;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 82;

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           cfg_valid      = 1'b0;
  logic           cfg_ready;
  rrcd_pkg::cfg_t cfg_data       = '0;
  logic           in_valid       = 1'b0;
  logic           in_ready;
  rrcd_pkg::cat_t category       = '0;
  rrcd_pkg::tag_t item_tag       = '0;
  logic           out_valid;
  logic           out_ready      = 1'b0;
  rrcd_pkg::cat_t destination;
  rrcd_pkg::tag_t routed_tag;
  rrcd_pkg::src_t source_id;
  rrcd_pkg::src_t next_source;
  logic           end_marker;
  logic           run_finished;
  logic           last;
  logic [31:0]    mismatches;
  logic [31:0]    pending;

  int             burst_left     = 0;
  int             hold_requests  = 0;
  int             idle_cycles    = 0;

  always #10 clk_i = ~clk_i;

  round_robin_category_dispatcher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .category_i     (category),
    .item_tag_i     (item_tag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .destination_o  (destination),
    .routed_tag_o   (routed_tag),
    .source_id_o    (source_id),
    .next_source_o  (next_source),
    .end_marker_o   (end_marker),
    .run_finished_o (run_finished),
    .last_o         (last)
  );

  rrcd_route_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .category_i     (category),
    .item_tag_i     (item_tag),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .destination_i  (destination),
    .routed_tag_i   (routed_tag),
    .source_id_i    (source_id),
    .next_source_i  (next_source),
    .end_marker_i   (end_marker),
    .run_finished_i (run_finished),
    .last_i         (last),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // offer one item beat and hold it until taken
  task automatic send_item(input rrcd_pkg::cat_t cat, input rrcd_pkg::tag_t tag);
    @(negedge clk_i);
    in_valid <= 1'b1;
    category <= cat;
    item_tag <= tag;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // drop valid for a number of cycles
  task automatic go_idle(input int cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // sender bursts with random gaps, sometimes back to back
  task automatic pace_sender();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        go_idle($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // drain all owed beats, let the block settle, then write the count register
  task automatic write_count(input rrcd_pkg::cfg_t value);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic rrcd_pkg::tag_t pick_tag();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return rrcd_pkg::tag_t'($urandom());
    endcase
  endfunction

  // result sink: segments of random pacing, plus a long hold-off on request
  initial begin : sink_pacing
    int mode;
    int seg;
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      mode = $urandom_range(SINK_OPEN, SINK_TOGGLE);
      seg  = $urandom_range(16, 96);
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_requests != hold_seen) begin
          hold_seen = hold_requests;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left--;
        end else begin
          case (mode)
            SINK_OPEN:   out_ready <= 1'b1;
            SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
            SINK_TIGHT:  out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rrcd_pkg::cfg_t phase_counts [6];
    int unsigned    done_pct;
    rrcd_pkg::cat_t cat;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default count of four: every category, tag extremes, full run to the end markers
    send_item(CAT_SPORTS, '0);
    send_item(CAT_WEATHER, '1);
    send_item(CAT_NEWS, 32'h5a5a_5a5a);
    send_item(CAT_SPORTS, 32'ha5a5_a5a5);
    send_item(rrcd_pkg::CAT_DONE, 32'hdead_beef);
    send_item(CAT_WEATHER, 32'h0000_0001);
    send_item(rrcd_pkg::CAT_DONE, '0);
    send_item(rrcd_pkg::CAT_DONE, '1);
    send_item(CAT_NEWS, 32'h8000_0000);
    send_item(rrcd_pkg::CAT_DONE, 32'h1234_5678);

    // zero count clamps to one source; a run opened by a done item
    write_count(5'd0);
    send_item(CAT_NEWS, 32'h1234_5678);
    send_item(rrcd_pkg::CAT_DONE, 32'h0f0f_0f0f);
    send_item(rrcd_pkg::CAT_DONE, 32'hf0f0_f0f0);

    // count above the list size clamps to sixteen
    write_count(5'd31);
    send_item(CAT_SPORTS, 32'h7fff_ffff);
    send_item(rrcd_pkg::CAT_DONE, 32'hffff_fffe);
    send_item(CAT_WEATHER, 32'h0000_0002);
    send_item(rrcd_pkg::CAT_DONE, 32'hcafe_f00d);

    // random phases, each with its own count and share of done items
    phase_counts = '{5'd16, 5'd1, 5'd17, 5'd2, rrcd_pkg::cfg_t'($urandom_range(0, 31)),
                     rrcd_pkg::cfg_t'($urandom_range(1, 8))};
    for (int p = 0; p < 6; p++) begin
      write_count(phase_counts[p]);
      done_pct = $urandom_range(15, 45);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pace_sender();
        if ($urandom_range(0, 99) < done_pct) begin
          cat = rrcd_pkg::CAT_DONE;
        end else begin
          cat = rrcd_pkg::cat_t'($urandom_range(CAT_SPORTS, CAT_NEWS));
        end
        send_item(cat, pick_tag());
        // long sink hold-off while the sender keeps offering
        if (p == 2 && i == 10) begin
          hold_requests++;
          burst_left = PHASE_ITEMS;
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rrcd_pkg.sv
rtl/rrcd_ram.sv
rtl/rrcd_ctrl.sv
rtl/round_robin_category_dispatcher.sv
test/rrcd_route_checker.sv
test/testbench.sv
